@@ design/fta_pkg.sv @@
`default_nettype none

package fta_pkg;

  localparam int unsigned VEC_W  = 32;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic signed [VEC_W-1:0] z;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } fta_vec_t;

  typedef struct packed {
    fta_vec_t        push;
    fta_vec_t        point;
    logic [ID_W-1:0] ident;
  } fta_entry_t;

  typedef enum logic [3:0] {
    S_DIFF,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_MUL5,
    S_TAIL,
    S_ACC2
  } fta_step_e;

  typedef struct packed {
    logic      clr;
    logic      run;
    fta_step_e step;
  } fta_dp_ctrl_t;

endpackage

`default_nettype wire

@@ design/fta_table.sv @@
`default_nettype none

module fta_table import fta_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic       clk_i,
  input  wire logic       we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire fta_entry_t wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output fta_entry_t      rdata_o
);

  fta_entry_t mem_q [DEPTH];
  fta_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/fta_datapath.sv @@
`default_nettype none

module fta_datapath import fta_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire fta_dp_ctrl_t ctrl_i,
  input  wire fta_entry_t   entry_i,
  input  wire fta_vec_t     center_i,
  output fta_vec_t     force_sum_o,
  output fta_vec_t     torque_sum_o,
  output logic         sat_o
);

  localparam logic [VEC_W-1:0] MAX_V = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic [VEC_W-1:0] MIN_V = {1'b1, {(VEC_W-1){1'b0}}};

  // returns {overflow, value}
  function automatic logic [VEC_W:0] sat_add(logic signed [VEC_W-1:0] a,
                                             logic signed [VEC_W-1:0] b,
                                             logic sub);
    logic signed [VEC_W:0] s;
    s = sub ? ({a[VEC_W-1], a} - {b[VEC_W-1], b}) : ({a[VEC_W-1], a} + {b[VEC_W-1], b});
    if (s[VEC_W] != s[VEC_W-1]) begin
      return {1'b1, (s[VEC_W] ? MIN_V : MAX_V)};
    end
    return {1'b0, s[VEC_W-1:0]};
  endfunction

  function automatic logic [VEC_W:0] sat_wide(logic signed [2*VEC_W-1:0] v);
    if ((&v[2*VEC_W-1:VEC_W-1]) || !(|v[2*VEC_W-1:VEC_W-1])) begin
      return {1'b0, v[VEC_W-1:0]};
    end
    return {1'b1, (v[2*VEC_W-1] ? MIN_V : MAX_V)};
  endfunction

  fta_vec_t                d_q;
  fta_vec_t                facc_q;
  fta_vec_t                tacc_q;
  logic signed [2*VEC_W-1:0] prod_q;
  logic signed [2*VEC_W-1:0] ta_q;
  logic signed [VEC_W-1:0] tv_q;
  logic                    sat_q;

  logic signed [VEC_W-1:0]   mul_a;
  logic signed [VEC_W-1:0]   mul_b;
  logic signed [2*VEC_W-1:0] prod_sh;
  logic signed [2*VEC_W-1:0] diff;
  logic [VEC_W:0]            wide_r;
  logic [VEC_W:0]            dx_r, dy_r, dz_r;
  logic [VEC_W:0]            fx_r, fy_r, fz_r;
  logic signed [VEC_W-1:0]   acc_sel;
  logic [VEC_W:0]            acc_r;

  always_comb begin
    case (ctrl_i.step)
      S_MUL0: begin mul_a = d_q.y; mul_b = entry_i.push.z; end
      S_MUL1: begin mul_a = d_q.z; mul_b = entry_i.push.y; end
      S_MUL2: begin mul_a = d_q.z; mul_b = entry_i.push.x; end
      S_MUL3: begin mul_a = d_q.x; mul_b = entry_i.push.z; end
      S_MUL4: begin mul_a = d_q.x; mul_b = entry_i.push.y; end
      S_MUL5: begin mul_a = d_q.y; mul_b = entry_i.push.x; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    case (ctrl_i.step)
      S_MUL3:  acc_sel = tacc_q.x;
      S_MUL5:  acc_sel = tacc_q.y;
      default: acc_sel = tacc_q.z;
    endcase
  end

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign diff    = ta_q - prod_sh;
  assign wide_r  = sat_wide(diff);
  assign acc_r   = sat_add(acc_sel, tv_q, 1'b0);
  assign dx_r    = sat_add(entry_i.point.x, center_i.x, 1'b1);
  assign dy_r    = sat_add(entry_i.point.y, center_i.y, 1'b1);
  assign dz_r    = sat_add(entry_i.point.z, center_i.z, 1'b1);
  assign fx_r    = sat_add(facc_q.x, entry_i.push.x, 1'b0);
  assign fy_r    = sat_add(facc_q.y, entry_i.push.y, 1'b0);
  assign fz_r    = sat_add(facc_q.z, entry_i.push.z, 1'b0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      facc_q <= '0;
      tacc_q <= '0;
      sat_q  <= 1'b0;
    end else if (ctrl_i.run) begin
      prod_q <= mul_a * mul_b;
      case (ctrl_i.step)
        S_DIFF: begin
          d_q.x  <= dx_r[VEC_W-1:0];
          d_q.y  <= dy_r[VEC_W-1:0];
          d_q.z  <= dz_r[VEC_W-1:0];
          facc_q <= {fz_r[VEC_W-1:0], fy_r[VEC_W-1:0], fx_r[VEC_W-1:0]};
          sat_q  <= sat_q | dx_r[VEC_W] | dy_r[VEC_W] | dz_r[VEC_W]
                    | fx_r[VEC_W] | fy_r[VEC_W] | fz_r[VEC_W];
        end
        S_MUL1: begin
          ta_q <= prod_sh;
        end
        S_MUL2, S_MUL4, S_TAIL: begin
          tv_q  <= wide_r[VEC_W-1:0];
          sat_q <= sat_q | wide_r[VEC_W];
        end
        S_MUL3: begin
          ta_q     <= prod_sh;
          tacc_q.x <= acc_r[VEC_W-1:0];
          sat_q    <= sat_q | acc_r[VEC_W];
        end
        S_MUL5: begin
          ta_q     <= prod_sh;
          tacc_q.y <= acc_r[VEC_W-1:0];
          sat_q    <= sat_q | acc_r[VEC_W];
        end
        S_ACC2: begin
          tacc_q.z <= acc_r[VEC_W-1:0];
          sat_q    <= sat_q | acc_r[VEC_W];
        end
        default: begin
        end
      endcase
    end
  end

  assign force_sum_o  = facc_q;
  assign torque_sum_o = tacc_q;
  assign sat_o        = sat_q;

endmodule

`default_nettype wire

@@ design/force_torque_accumulator_top.sv @@
`default_nettype none

// Force and torque accumulator. Holds up to TABLE_ENTRIES force applications
// (id, point, force; point and force Q16.16 with FRAC_BITS fraction bits) in a
// table with one read and one write port and answers one result item per input
// item. An add walks the used entries one per cycle to find the last matching
// id, then writes. A compute sends every used entry through one shared 32x32
// multiplier, six products per entry. A clear or an unused mode goes straight
// to the result. One item is in work at a time; the result sits in an output
// register so the next item can be taken while it waits. The table is not
// cleared at reset and needs no setup.
module force_torque_accumulator_top import fta_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // item_id, pos_x, pos_y, pos_z, push_x, push_y, push_z
  input  wire logic [207:0] s_axis_tdata,
  // mode
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // sum_force_x/y/z, sum_torque_x/y/z, last_point_x/y/z
  output logic [287:0]      m_axis_tdata,
  // status
  output logic [1:0]        m_axis_tuser
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    IDLE,
    PRIME,
    SCAN,
    WRITE,
    CRUN,
    FINISH
  } state_e;

  state_e              state_q;
  logic [MODE_W-1:0]   mode_q;
  fta_entry_t          in_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       idx_q;
  logic [AW-1:0]       slot_q;
  logic                found_q;
  fta_step_e           step_q;
  fta_vec_t            lp_q;
  logic [STAT_W-1:0]   status_q;
  logic                m_tvalid_q;
  logic [287:0]        m_tdata_q;
  logic [STAT_W-1:0]   m_tuser_q;

  logic                accept;
  logic                out_free;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       last_idx;
  logic [AW-1:0]       rd_addr;
  logic                tbl_we;
  logic [AW-1:0]       tbl_waddr;
  fta_entry_t          rd_entry;
  fta_dp_ctrl_t        dp_ctrl;
  fta_vec_t            force_sum;
  fta_vec_t            torque_sum;
  logic                dp_sat;

  assign s_axis_tready = (state_q == IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign idx_inc       = idx_q + 1'b1;
  assign last_idx      = count_q - 1'b1;

  always_comb begin
    case (state_q)
      SCAN:    rd_addr = idx_inc[AW-1:0];
      CRUN:    rd_addr = (step_q == S_ACC2) ? idx_inc[AW-1:0] : idx_q[AW-1:0];
      default: rd_addr = idx_q[AW-1:0];
    endcase
  end

  assign tbl_we    = (state_q == WRITE) && (found_q || (count_q < FULL_CNT));
  assign tbl_waddr = found_q ? slot_q : count_q[AW-1:0];

  assign dp_ctrl.clr  = accept && (s_axis_tuser == MODE_COMPUTE);
  assign dp_ctrl.run  = (state_q == CRUN);
  assign dp_ctrl.step = step_q;

  fta_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (in_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  fta_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (dp_ctrl),
    .entry_i      (rd_entry),
    .center_i     (in_q.point),
    .force_sum_o  (force_sum),
    .torque_sum_o (torque_sum),
    .sat_o        (dp_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= IDLE;
      mode_q     <= MODE_ADD;
      in_q       <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      slot_q     <= '0;
      found_q    <= 1'b0;
      step_q     <= S_DIFF;
      lp_q       <= '0;
      status_q   <= STATUS_OK;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= STATUS_OK;
    end else begin
      if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (accept) begin
            mode_q   <= s_axis_tuser;
            in_q     <= fta_entry_t'(s_axis_tdata);
            idx_q    <= '0;
            found_q  <= 1'b0;
            step_q   <= S_DIFF;
            lp_q     <= '0;
            status_q <= STATUS_OK;
            case (s_axis_tuser)
              MODE_ADD: begin
                state_q <= (count_q == '0) ? WRITE : PRIME;
              end
              MODE_COMPUTE: begin
                state_q <= (count_q == '0) ? FINISH : PRIME;
              end
              MODE_CLEAR: begin
                count_q <= '0;
                state_q <= FINISH;
              end
              default: begin
                state_q <= FINISH;
              end
            endcase
          end
        end
        PRIME: begin
          state_q <= (mode_q == MODE_ADD) ? SCAN : CRUN;
        end
        SCAN: begin
          if (rd_entry.ident == in_q.ident) begin
            found_q <= 1'b1;
            slot_q  <= idx_q[AW-1:0];
          end
          if (idx_q == last_idx) begin
            state_q <= WRITE;
          end else begin
            idx_q <= idx_inc;
          end
        end
        WRITE: begin
          if (!found_q) begin
            if (count_q < FULL_CNT) begin
              count_q <= count_q + 1'b1;
            end else begin
              status_q <= STATUS_FULL;
            end
          end
          state_q <= FINISH;
        end
        CRUN: begin
          if (step_q == S_DIFF) begin
            lp_q <= rd_entry.point;
          end
          if (step_q == S_ACC2) begin
            step_q <= S_DIFF;
            if (idx_q == last_idx) begin
              state_q <= FINISH;
            end else begin
              idx_q <= idx_inc;
            end
          end else begin
            step_q <= fta_step_e'(step_q + 1'b1);
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            if (mode_q == MODE_COMPUTE) begin
              m_tdata_q <= {lp_q, torque_sum, force_sum};
              m_tuser_q <= dp_sat ? STATUS_SAT : STATUS_OK;
            end else begin
              m_tdata_q <= '0;
              m_tuser_q <= status_q;
            end
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

`default_nettype wire

@@ design/fta_checker.sv @@
`default_nettype none

module fta_checker import fta_pkg::*; (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [287:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_FULL)
      || (m_axis_tuser == STATUS_SAT))
    else $error("status code out of range");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |-> (m_axis_tdata == '0))
    else $error("full table result carries data");

endmodule

bind force_torque_accumulator_top fta_checker u_fta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
